>>> design/assert_macros.svh
// Assertion helpers for the checker in lpp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion violated");

`endif

>>> design/lpp_pkg.sv
package lpp_pkg;

	localparam int BASIS_W   = 11;
	localparam int ORG_W     = 16;
	localparam int FRAC_W    = 5;
	localparam int PT_W      = 16;
	localparam int DIFF_W    = 17;
	localparam int MUL_N_W   = 31;
	localparam int PROD_W    = BASIS_W + MUL_N_W;
	localparam int MAC_W     = PROD_W + 1;
	localparam int NUM_MAG_W = 28;
	localparam int DIV_NUM_W = 44;
	localparam int DIV_DEN_W = 22;
	localparam int DIV_CNT_W = 6;
	localparam int PROJ_W    = DIV_NUM_W + 1;
	localparam int NODE_W    = 31;
	localparam int OFF_W     = 16;
	localparam int SNAP_W    = 32;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	localparam logic [FRAC_W-1:0] FRAC_MIN = 5'd1;
	localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd16;

	localparam logic signed [NODE_W-1:0] EXT_POS_MAX = {1'b0, {(NODE_W-1){1'b1}}};
	localparam logic signed [NODE_W-1:0] EXT_NEG_MIN = {1'b1, {(NODE_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_BASIS_U_X,
		REG_BASIS_V_X,
		REG_BASIS_U_Y,
		REG_BASIS_V_Y,
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_FRAC_BITS
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DET,
		ST_NX,
		ST_NY,
		ST_PREP,
		ST_START,
		ST_DIV,
		ST_ROUND,
		ST_NODE,
		ST_SX,
		ST_SY,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic signed [BASIS_W-1:0] basis_u_x;
		logic signed [BASIS_W-1:0] basis_v_x;
		logic signed [BASIS_W-1:0] basis_u_y;
		logic signed [BASIS_W-1:0] basis_v_y;
		logic signed [ORG_W-1:0]   origin_x;
		logic signed [ORG_W-1:0]   origin_y;
		logic [FRAC_W-1:0]         frac_eff;
	} lpp_cfg_t;

	typedef struct packed {
		logic signed [BASIS_W-1:0] m0;
		logic signed [MUL_N_W-1:0] n0;
		logic signed [BASIS_W-1:0] m1;
		logic signed [MUL_N_W-1:0] n1;
		logic                      sub;
	} mac_op_t;

endpackage

>>> design/lattice_point_projection_top.sv
// Channel | Handshake                     | Payload
// --------+-------------------------------+-------------------------------------------------
// point   | point_valid / point_ready     | point_x, point_y, last_point
// result  | result_valid / result_ready   | lattice_*, offset_*, snapped_*, extent_*, singular
// config  | psel, penable, pwrite, pready | paddr (reg at 4*i), pwdata, prdata
//
// The sequencer takes one point at a time; a singular basis goes from the determinant step
// straight to write-back. The two-lane radix-2 divider (one quotient bit a cycle over a
// 44-bit scaled numerator) holds the sequencer while it runs; one shared multiply-add unit
// computes the determinant, both adjugate products and the snapped node in turn. point_ready
// is high only while the sequencer idles; a waiting result stalls only the final write-back
// step. Reset clears the sequencer, result valid and extents and presets the registers.
module lattice_point_projection_top import lpp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	input  logic                     point_valid,
	output logic                     point_ready,
	input  logic signed [PT_W-1:0]   point_x,
	input  logic signed [PT_W-1:0]   point_y,
	input  logic                     last_point,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [NODE_W-1:0] lattice_col,
	output logic signed [NODE_W-1:0] lattice_row,
	output logic signed [OFF_W-1:0]  offset_col,
	output logic signed [OFF_W-1:0]  offset_row,
	output logic signed [SNAP_W-1:0] snapped_x,
	output logic signed [SNAP_W-1:0] snapped_y,
	output logic signed [NODE_W-1:0] extent_col_min,
	output logic signed [NODE_W-1:0] extent_col_max,
	output logic signed [NODE_W-1:0] extent_row_min,
	output logic signed [NODE_W-1:0] extent_row_max,
	output logic                     singular
);

	localparam int OFFX_W = OFF_W + 1;

	lpp_cfg_t cfg;
	mac_op_t  mac_op;
	logic signed [MAC_W-1:0] mac_res;
	logic [MAC_W-1:0]        mac_mag;

	seq_state_t state_q, state_d;
	logic       div_start, div_done, load_out;
	logic [DIV_NUM_W-1:0] quo0, quo1, num0, num1;

	// request payload and intermediate results
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic                     last_q, sing_q;
	logic [DIV_DEN_W-1:0]     det_mag_q;
	logic                     det_neg_q;
	logic [NUM_MAG_W-1:0]     nx_mag_q, ny_mag_q;
	logic                     nx_neg_q, ny_neg_q;
	logic signed [PROJ_W-1:0] rnd_col_q, rnd_row_q;
	logic signed [NODE_W-1:0] col_q, row_q;
	logic signed [OFF_W-1:0]  ocol_q, orow_q;
	logic [SNAP_W-1:0]        sx_q;

	// running extents
	logic signed [NODE_W-1:0] run_col_min_q, run_col_max_q, run_row_min_q, run_row_max_q;
	logic signed [NODE_W-1:0] ext_col_min, ext_col_max, ext_row_min, ext_row_max;

	// rounding helpers
	logic [PROJ_W-1:0] half_proj;
	logic [OFFX_W-1:0] half_off;
	logic [OFF_W-1:0]  frac_mask;

	// result register
	logic                     result_valid_q;
	logic signed [NODE_W-1:0] out_col_q, out_row_q;
	logic signed [OFF_W-1:0]  out_ocol_q, out_orow_q;
	logic signed [SNAP_W-1:0] out_sx_q, out_sy_q;
	logic signed [NODE_W-1:0] out_cmin_q, out_cmax_q, out_rmin_q, out_rmax_q;
	logic                     out_sing_q;

	function automatic mac_op_t make_op(
		input logic signed [BASIS_W-1:0] m0,
		input logic signed [MUL_N_W-1:0] n0,
		input logic signed [BASIS_W-1:0] m1,
		input logic signed [MUL_N_W-1:0] n1,
		input logic                      sub
	);
		mac_op_t op;
		op.m0  = m0;
		op.n0  = n0;
		op.m1  = m1;
		op.n1  = n1;
		op.sub = sub;
		return op;
	endfunction

	lpp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lpp_mac u_mac (
		.clk   (clk),
		.op    (mac_op),
		.res_q (mac_res)
	);

	// scale both numerators by 2^p before the divide
	assign num0 = DIV_NUM_W'(nx_mag_q) << cfg.frac_eff;
	assign num1 = DIV_NUM_W'(ny_mag_q) << cfg.frac_eff;

	lpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (det_mag_q),
		.num0   (num0),
		.num1   (num1),
		.quo0   (quo0),
		.quo1   (quo1),
		.done   (div_done)
	);

	assign pready      = 1'b1;
	assign point_ready = (state_q == ST_IDLE);

	assign mac_mag   = mac_res[MAC_W-1] ? MAC_W'(-mac_res) : MAC_W'(mac_res);
	assign half_proj = PROJ_W'(1) << (cfg.frac_eff - FRAC_W'(1));
	assign half_off  = OFFX_W'(1) << (cfg.frac_eff - FRAC_W'(1));
	assign frac_mask = OFF_W'((OFFX_W'(1) << cfg.frac_eff) - OFFX_W'(1));

	// Sequencer: feed the shared multiply-add one product pair per step, then divide,
	// round, snap back and hand the result to the output register.
	always_comb begin
		state_d   = state_q;
		mac_op    = '0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					state_d = ST_DET;
				end
			end
			ST_DET: begin
				// det = a*d - c*b
				mac_op  = make_op(cfg.basis_u_x, MUL_N_W'(cfg.basis_v_y),
					cfg.basis_u_y, MUL_N_W'(cfg.basis_v_x), 1'b1);
				state_d = ST_NX;
			end
			ST_NX: begin
				// d*dx - b*dy; determinant is on the unit output now
				mac_op  = make_op(cfg.basis_v_y, MUL_N_W'(dx_q),
					cfg.basis_v_x, MUL_N_W'(dy_q), 1'b1);
				state_d = (mac_res == '0) ? ST_DONE : ST_NY;
			end
			ST_NY: begin
				// a*dy - c*dx
				mac_op  = make_op(cfg.basis_u_x, MUL_N_W'(dy_q),
					cfg.basis_u_y, MUL_N_W'(dx_q), 1'b1);
				state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				state_d = ST_NODE;
			end
			ST_NODE: begin
				state_d = ST_SX;
			end
			ST_SX: begin
				mac_op  = make_op(cfg.basis_u_x, col_q, cfg.basis_v_x, row_q, 1'b0);
				state_d = ST_SY;
			end
			ST_SY: begin
				mac_op  = make_op(cfg.basis_u_y, col_q, cfg.basis_v_y, row_q, 1'b0);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold the y operands so the unit output stays put while stalled
				mac_op = make_op(cfg.basis_u_y, col_q, cfg.basis_v_y, row_q, 1'b0);
				if (!result_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath capture, one step per sequencer state.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					dx_q   <= DIFF_W'(point_x) - DIFF_W'(cfg.origin_x);
					dy_q   <= DIFF_W'(point_y) - DIFF_W'(cfg.origin_y);
					last_q <= last_point;
				end
			end
			ST_NX: begin
				det_mag_q <= mac_mag[DIV_DEN_W-1:0];
				det_neg_q <= mac_res[MAC_W-1];
				sing_q    <= (mac_res == '0);
			end
			ST_NY: begin
				nx_mag_q <= mac_mag[NUM_MAG_W-1:0];
				nx_neg_q <= mac_res[MAC_W-1];
			end
			ST_PREP: begin
				ny_mag_q <= mac_mag[NUM_MAG_W-1:0];
				ny_neg_q <= mac_res[MAC_W-1];
			end
			ST_ROUND: begin
				// apply the quotient sign and add half a node in one step
				rnd_col_q <= (nx_neg_q ^ det_neg_q) ? half_proj - {1'b0, quo0}
					: {1'b0, quo0} + half_proj;
				rnd_row_q <= (ny_neg_q ^ det_neg_q) ? half_proj - {1'b0, quo1}
					: {1'b0, quo1} + half_proj;
			end
			ST_NODE: begin
				col_q  <= NODE_W'(rnd_col_q >>> cfg.frac_eff);
				row_q  <= NODE_W'(rnd_row_q >>> cfg.frac_eff);
				ocol_q <= OFF_W'({1'b0, rnd_col_q[OFF_W-1:0] & frac_mask} - half_off);
				orow_q <= OFF_W'({1'b0, rnd_row_q[OFF_W-1:0] & frac_mask} - half_off);
			end
			ST_SY: begin
				sx_q <= mac_res[SNAP_W-1:0] + SNAP_W'(cfg.origin_x);
			end
			default: ;
		endcase
	end

	// extents including the current node
	assign ext_col_min = (col_q < run_col_min_q) ? col_q : run_col_min_q;
	assign ext_col_max = (col_q > run_col_max_q) ? col_q : run_col_max_q;
	assign ext_row_min = (row_q < run_row_min_q) ? row_q : run_row_min_q;
	assign ext_row_max = (row_q > run_row_max_q) ? row_q : run_row_max_q;

	// Advance the extents on write-back unless the basis is singular; drop them after the last point of a set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_col_min_q <= EXT_POS_MAX;
			run_col_max_q <= EXT_NEG_MIN;
			run_row_min_q <= EXT_POS_MAX;
			run_row_max_q <= EXT_NEG_MIN;
		end else if (load_out) begin
			if (last_q) begin
				run_col_min_q <= EXT_POS_MAX;
				run_col_max_q <= EXT_NEG_MIN;
				run_row_min_q <= EXT_POS_MAX;
				run_row_max_q <= EXT_NEG_MIN;
			end else if (!sing_q) begin
				run_col_min_q <= ext_col_min;
				run_col_max_q <= ext_col_max;
				run_row_min_q <= ext_row_min;
				run_row_max_q <= ext_row_max;
			end
		end
	end

	// Result register: hold while the consumer stalls, refill as it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sing_q <= sing_q;
			if (sing_q) begin
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_ocol_q <= '0;
				out_orow_q <= '0;
				out_sx_q   <= '0;
				out_sy_q   <= '0;
				out_cmin_q <= '0;
				out_cmax_q <= '0;
				out_rmin_q <= '0;
				out_rmax_q <= '0;
			end else begin
				out_col_q  <= col_q;
				out_row_q  <= row_q;
				out_ocol_q <= ocol_q;
				out_orow_q <= orow_q;
				out_sx_q   <= sx_q;
				out_sy_q   <= mac_res[SNAP_W-1:0] + SNAP_W'(cfg.origin_y);
				out_cmin_q <= ext_col_min;
				out_cmax_q <= ext_col_max;
				out_rmin_q <= ext_row_min;
				out_rmax_q <= ext_row_max;
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign lattice_col    = out_col_q;
	assign lattice_row    = out_row_q;
	assign offset_col     = out_ocol_q;
	assign offset_row     = out_orow_q;
	assign snapped_x      = out_sx_q;
	assign snapped_y      = out_sy_q;
	assign extent_col_min = out_cmin_q;
	assign extent_col_max = out_cmax_q;
	assign extent_row_min = out_rmin_q;
	assign extent_row_max = out_rmax_q;
	assign singular       = out_sing_q;

endmodule

>>> design/lpp_regs.sv
module lpp_regs import lpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output lpp_cfg_t          cfg
);

	logic signed [BASIS_W-1:0] basis_u_x_q, basis_v_x_q, basis_u_y_q, basis_v_y_q;
	logic signed [ORG_W-1:0]   origin_x_q, origin_y_q;
	logic [FRAC_W-1:0]         frac_bits_q;
	logic [2:0]                idx;
	logic                      wr;

	assign idx = paddr[APB_AW-1:2];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_u_x_q <= BASIS_W'(1);
			basis_v_x_q <= '0;
			basis_u_y_q <= '0;
			basis_v_y_q <= BASIS_W'(1);
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			frac_bits_q <= FRAC_W'(8);
		end else if (wr) begin
			unique case (idx)
				REG_BASIS_U_X: basis_u_x_q <= pwdata[BASIS_W-1:0];
				REG_BASIS_V_X: basis_v_x_q <= pwdata[BASIS_W-1:0];
				REG_BASIS_U_Y: basis_u_y_q <= pwdata[BASIS_W-1:0];
				REG_BASIS_V_Y: basis_v_y_q <= pwdata[BASIS_W-1:0];
				REG_ORIGIN_X:  origin_x_q  <= pwdata[ORG_W-1:0];
				REG_ORIGIN_Y:  origin_y_q  <= pwdata[ORG_W-1:0];
				REG_FRAC_BITS: frac_bits_q <= pwdata[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BASIS_U_X: prdata = APB_DW'(basis_u_x_q);
			REG_BASIS_V_X: prdata = APB_DW'(basis_v_x_q);
			REG_BASIS_U_Y: prdata = APB_DW'(basis_u_y_q);
			REG_BASIS_V_Y: prdata = APB_DW'(basis_v_y_q);
			REG_ORIGIN_X:  prdata = APB_DW'(origin_x_q);
			REG_ORIGIN_Y:  prdata = APB_DW'(origin_y_q);
			REG_FRAC_BITS: prdata = APB_DW'(frac_bits_q);
			default:       prdata = '0;
		endcase
	end

	// clamp the fraction width to 1..16
	always_comb begin
		cfg.basis_u_x = basis_u_x_q;
		cfg.basis_v_x = basis_v_x_q;
		cfg.basis_u_y = basis_u_y_q;
		cfg.basis_v_y = basis_v_y_q;
		cfg.origin_x  = origin_x_q;
		cfg.origin_y  = origin_y_q;
		if (frac_bits_q < FRAC_MIN) begin
			cfg.frac_eff = FRAC_MIN;
		end else if (frac_bits_q > FRAC_MAX) begin
			cfg.frac_eff = FRAC_MAX;
		end else begin
			cfg.frac_eff = frac_bits_q;
		end
	end

endmodule

>>> design/lpp_mac.sv
module lpp_mac import lpp_pkg::*; (
	input  logic                    clk,
	input  mac_op_t                 op,
	output logic signed [MAC_W-1:0] res_q
);

	logic signed [PROD_W-1:0] prod0, prod1;
	logic signed [MAC_W-1:0]  res_d;

	assign prod0 = op.m0 * op.n0;
	assign prod1 = op.m1 * op.n1;
	assign res_d = op.sub ? MAC_W'(prod0) - MAC_W'(prod1) : MAC_W'(prod0) + MAC_W'(prod1);

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

endmodule

>>> design/lpp_div.sv
module lpp_div import lpp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_DEN_W-1:0] den,
	input  logic [DIV_NUM_W-1:0] num0,
	input  logic [DIV_NUM_W-1:0] num1,
	output logic [DIV_NUM_W-1:0] quo0,
	output logic [DIV_NUM_W-1:0] quo1,
	output logic                 done
);

	// two lanes share divisor and step counter; one quotient bit per cycle
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q [2];
	logic [DIV_DEN_W-1:0] rem_q [2];
	logic [DIV_DEN_W:0]   sh    [2];
	logic [DIV_DEN_W+1:0] diff  [2];
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sh[i]   = {rem_q[i], quo_q[i][DIV_NUM_W-1]};
			diff[i] = {1'b0, sh[i]} - {2'b00, den_q};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q    <= den;
			quo_q[0] <= num0;
			quo_q[1] <= num1;
			rem_q[0] <= '0;
			rem_q[1] <= '0;
		end else if (busy_q) begin
			for (int i = 0; i < 2; i++) begin
				if (!diff[i][DIV_DEN_W+1]) begin
					rem_q[i] <= diff[i][DIV_DEN_W-1:0];
					quo_q[i] <= {quo_q[i][DIV_NUM_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= sh[i][DIV_DEN_W-1:0];
					quo_q[i] <= {quo_q[i][DIV_NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quo0 = quo_q[0];
	assign quo1 = quo_q[1];
	assign done = done_q;

endmodule

>>> design/lpp_checker.sv
`include "assert_macros.svh"

module lpp_checker import lpp_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     point_valid,
	input logic                     point_ready,
	input logic                     result_valid,
	input logic                     result_ready,
	input logic signed [NODE_W-1:0] lattice_col,
	input logic signed [NODE_W-1:0] lattice_row,
	input logic signed [SNAP_W-1:0] snapped_x,
	input logic signed [SNAP_W-1:0] snapped_y,
	input logic signed [NODE_W-1:0] extent_col_min,
	input logic signed [NODE_W-1:0] extent_col_max,
	input logic signed [NODE_W-1:0] extent_row_min,
	input logic signed [NODE_W-1:0] extent_row_max,
	input logic                     singular
);

	// one point in flight: busy right after a request is taken
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, point_valid && point_ready, !point_ready)

	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(lattice_col) && $stable(snapped_x))

	`ASSERT_SAME(a_singular_zero, clk, arst_n, result_valid && singular, lattice_col == 0 && lattice_row == 0 && snapped_x == 0 && snapped_y == 0)

	`ASSERT_SAME(a_extent_span, clk, arst_n, result_valid && !singular, extent_col_min <= lattice_col && lattice_col <= extent_col_max && extent_row_min <= lattice_row && lattice_row <= extent_row_max)

endmodule

bind lattice_point_projection_top lpp_checker u_lpp_checker (.*);

>>> tb/lattice_point_projection_top_test.sv
`timescale 1ns / 1ps

module lattice_point_projection_top_test;
	import lpp_pkg::*;

	// Index 7 has no register behind it. The block must drop writes to it.
	localparam logic [2:0] REG_SPARE = 3'd7;
	// This must cover one point from request to result. Leave some slack.
	localparam int SEQ_LATENCY = 64;
	// Print only the first mismatches. A broken block should not flood the log.
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic signed [NODE_W-1:0] col;
		logic signed [NODE_W-1:0] row;
		logic signed [OFF_W-1:0]  ocol;
		logic signed [OFF_W-1:0]  orow;
		logic signed [SNAP_W-1:0] sx;
		logic signed [SNAP_W-1:0] sy;
		logic signed [NODE_W-1:0] cmin;
		logic signed [NODE_W-1:0] cmax;
		logic signed [NODE_W-1:0] rmin;
		logic signed [NODE_W-1:0] rmax;
		logic                     sing;
	} lattice_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_AW-1:0]        paddr;
	logic [APB_DW-1:0]        pwdata;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     point_valid;
	logic                     point_ready;
	logic signed [PT_W-1:0]   point_x;
	logic signed [PT_W-1:0]   point_y;
	logic                     last_point;
	logic                     result_valid;
	logic                     result_ready;
	logic signed [NODE_W-1:0] lattice_col;
	logic signed [NODE_W-1:0] lattice_row;
	logic signed [OFF_W-1:0]  offset_col;
	logic signed [OFF_W-1:0]  offset_row;
	logic signed [SNAP_W-1:0] snapped_x;
	logic signed [SNAP_W-1:0] snapped_y;
	logic signed [NODE_W-1:0] extent_col_min;
	logic signed [NODE_W-1:0] extent_col_max;
	logic signed [NODE_W-1:0] extent_row_min;
	logic signed [NODE_W-1:0] extent_row_max;
	logic                     singular;

	lattice_point_projection_top u_top (.*);

	// Shadow copy of the block's registers and running extents. It is updated
	// at the same clock edges at which the block takes a write or a request.
	longint            lat_a, lat_b, lat_c, lat_d, lat_ox, lat_oy;
	logic [FRAC_W-1:0] lat_frac;
	longint            span_col_min, span_col_max, span_row_min, span_row_max;

	// Results still owed by the block, in request order.
	lattice_result_t   pending_projections [$];
	int                mismatch_count = 0;

	// Percentage of cycles in which the point source idles or the result sink
	// stalls. Each test phase sets these values.
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit. A correct run ends far earlier, even with the heaviest stalls.
	initial begin
		#20_000_000;
		$display("lattice_point_projection_top_test: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_spans();
		span_col_min = EXT_POS_MAX;
		span_row_min = EXT_POS_MAX;
		span_col_max = EXT_NEG_MIN;
		span_row_max = EXT_NEG_MIN;
	endfunction

	function automatic void apply_register(logic [2:0] idx, logic [APB_DW-1:0] v);
		case (idx)
			REG_BASIS_U_X: lat_a    = $signed(v[BASIS_W-1:0]);
			REG_BASIS_V_X: lat_b    = $signed(v[BASIS_W-1:0]);
			REG_BASIS_U_Y: lat_c    = $signed(v[BASIS_W-1:0]);
			REG_BASIS_V_Y: lat_d    = $signed(v[BASIS_W-1:0]);
			REG_ORIGIN_X:  lat_ox   = $signed(v[ORG_W-1:0]);
			REG_ORIGIN_Y:  lat_oy   = $signed(v[ORG_W-1:0]);
			REG_FRAC_BITS: lat_frac = v[FRAC_W-1:0];
			default: ;
		endcase
	endfunction

	// Round half up: floor of proj / 2^p, plus one when bit p-1 is set.
	function automatic longint nearest_node(longint proj, int p);
		longint n;
		n = proj >>> p;
		if (proj[p-1])
			n = n + 1;
		return n;
	endfunction

	function automatic lattice_result_t project_point(logic signed [PT_W-1:0] x,
			logic signed [PT_W-1:0] y, logic last_pt);
		lattice_result_t r;
		longint          det, dx, dy, px, py, col, row, ocol, orow, sx, sy;
		int              p;
		r = '{default: '0};
		det = lat_a * lat_d - lat_c * lat_b;
		if (det == 0) begin
			// A singular basis zeroes every field and leaves the extents alone.
			r.sing = 1'b1;
		end else begin
			p = lat_frac;
			if (p < FRAC_MIN)
				p = FRAC_MIN;
			if (p > FRAC_MAX)
				p = FRAC_MAX;
			dx = x - lat_ox;
			dy = y - lat_oy;
			// Adjugate times offset, scaled, divided with truncation toward zero.
			px = ((lat_d * dx - lat_b * dy) <<< p) / det;
			py = ((lat_a * dy - lat_c * dx) <<< p) / det;
			col = nearest_node(px, p);
			row = nearest_node(py, p);
			ocol = px - (col <<< p);
			orow = py - (row <<< p);
			if (col < span_col_min)
				span_col_min = col;
			if (col > span_col_max)
				span_col_max = col;
			if (row < span_row_min)
				span_row_min = row;
			if (row > span_row_max)
				span_row_max = row;
			sx = lat_a * col + lat_b * row + lat_ox;
			sy = lat_c * col + lat_d * row + lat_oy;
			r.col  = col[NODE_W-1:0];
			r.row  = row[NODE_W-1:0];
			r.ocol = ocol[OFF_W-1:0];
			r.orow = orow[OFF_W-1:0];
			r.sx   = sx[SNAP_W-1:0];
			r.sy   = sy[SNAP_W-1:0];
			r.cmin = span_col_min[NODE_W-1:0];
			r.cmax = span_col_max[NODE_W-1:0];
			r.rmin = span_row_min[NODE_W-1:0];
			r.rmax = span_row_max[NODE_W-1:0];
		end
		// The last point of a set clears the extents, even on a singular basis.
		if (last_pt)
			clear_spans();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result sink and checker
	// ------------------------------------------------------------------

	function automatic void compare_field(string name, longint want, longint got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= PRINT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Sample the outputs as they were before the edge, then roll the stall for
	// the next cycle. result_ready gets one assignment per edge here.
	always @(posedge clk) begin : result_sink
		lattice_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_projections.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= PRINT_LIMIT)
					$display("%0t: result with no request waiting, expected none, actual col %0d row %0d",
						$time, lattice_col, lattice_row);
			end else begin
				want = pending_projections.pop_front();
				compare_field("lattice_col", want.col, lattice_col);
				compare_field("lattice_row", want.row, lattice_row);
				compare_field("offset_col", want.ocol, offset_col);
				compare_field("offset_row", want.orow, offset_row);
				compare_field("snapped_x", want.sx, snapped_x);
				compare_field("snapped_y", want.sy, snapped_y);
				compare_field("extent_col_min", want.cmin, extent_col_min);
				compare_field("extent_col_max", want.cmax, extent_col_max);
				compare_field("extent_row_min", want.rmin, extent_row_min);
				compare_field("extent_row_max", want.rmax, extent_row_max);
				compare_field("singular", want.sing, singular);
			end
		end
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Do a setup cycle and then an access cycle. Mirror the write into the
	// shadow registers at the edge where it lands. Drop psel after the access
	// and wait for the next edge.
	task automatic apb_write(logic [2:0] idx, logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_register(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_lattice(logic signed [BASIS_W-1:0] a, logic signed [BASIS_W-1:0] b,
			logic signed [BASIS_W-1:0] c, logic signed [BASIS_W-1:0] d,
			logic signed [ORG_W-1:0] ox, logic signed [ORG_W-1:0] oy, logic [FRAC_W-1:0] fb);
		apb_write(REG_BASIS_U_X, 32'(a));
		apb_write(REG_BASIS_V_X, 32'(b));
		apb_write(REG_BASIS_U_Y, 32'(c));
		apb_write(REG_BASIS_V_Y, 32'(d));
		apb_write(REG_ORIGIN_X, 32'(ox));
		apb_write(REG_ORIGIN_Y, 32'(oy));
		apb_write(REG_FRAC_BITS, 32'(fb));
	endtask

	// Present one point request and return at the edge where it is taken.
	// Valid stays high when no idle gap is rolled, so requests can run back to
	// back. Lower valid only at the start of a gap, never in the accepting step.
	task automatic send_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
			logic last_pt);
		if ($urandom_range(99) < send_idle_pct) begin
			point_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		point_valid <= 1'b1;
		point_x     <= x;
		point_y     <= y;
		last_point  <= last_pt;
		do @(posedge clk); while (!point_ready);
		pending_projections.push_back(project_point(x, y, last_pt));
	endtask

	// Drop valid in the step of the last acceptance. Wait until every result
	// has come back so that the block is idle for register writes.
	task automatic settle();
		point_valid <= 1'b0;
		while (pending_projections.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset basis is the identity with 8 fractional bits. Drive the point
	// fields to their extremes and toggle last_point.
	task automatic test_identity_extremes();
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd32767, 16'sd32767, 1'b0);
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b1);
		send_point(-16'sd1, 16'sd1, 1'b0);
		send_point(16'sd5, -16'sd7, 1'b1);
		settle();
	endtask

	// Extreme basis components and origins, with the largest and the smallest
	// scaling. Then an even basis that lands projections exactly on half
	// steps, so rounding goes up on both signs.
	task automatic test_basis_extremes();
		program_lattice(-11'sd1024, 11'sd1023, 11'sd1023, -11'sd1024,
			-16'sd32768, 16'sd32767, 5'd16);
		send_point(16'sd32767, -16'sd32768, 1'b0);
		send_point(-16'sd32768, 16'sd32767, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b1);
		settle();
		program_lattice(11'sd1023, -11'sd1024, -11'sd1024, 11'sd1023,
			16'sd32767, -16'sd32768, 5'd1);
		send_point(-16'sd32768, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b1);
		settle();
		program_lattice(11'sd2, 11'sd0, 11'sd0, 11'sd2, 16'sd0, 16'sd0, 5'd4);
		send_point(16'sd3, -16'sd3, 1'b0);
		send_point(-16'sd1, 16'sd1, 1'b1);
		settle();
	endtask

	// A frac_bits of zero must act as one. Values above sixteen must act as
	// sixteen.
	task automatic test_frac_clamp();
		logic [FRAC_W-1:0] fracs [5] = '{5'd0, 5'd17, 5'd31, 5'd1, 5'd16};
		program_lattice(11'sd3, 11'sd1, -11'sd2, 11'sd5, 16'sd100, -16'sd50, 5'd8);
		foreach (fracs[i]) begin
			apb_write(REG_FRAC_BITS, 32'(fracs[i]));
			send_point(16'sd1234, -16'sd4321, 1'b0);
			settle();
		end
	endtask

	// Build up extents, then switch to a singular basis. Its last point must
	// clear the extents without adding to them. A write to the unmapped index
	// must change nothing.
	task automatic test_singular_and_spare();
		program_lattice(11'sd5, 11'sd1, 11'sd1, 11'sd5, 16'sd0, 16'sd0, 5'd6);
		send_point(16'sd300, -16'sd200, 1'b0);
		settle();
		program_lattice(11'sd2, 11'sd4, 11'sd1, 11'sd2, 16'sd100, -16'sd100, 5'd8);
		send_point(16'sd10, 16'sd20, 1'b0);
		send_point(-16'sd5, 16'sd7, 1'b1);
		settle();
		program_lattice(11'sd5, 11'sd1, 11'sd1, 11'sd5, 16'sd0, 16'sd0, 5'd6);
		apb_write(REG_SPARE, $urandom);
		send_point(-16'sd300, 16'sd200, 1'b1);
		settle();
	endtask

	// Small components in half the draws so that many points land near nodes. Some draws
	// are full width and some are the extremes.
	function automatic logic signed [BASIS_W-1:0] pick_component();
		case ($urandom_range(9))
			0:       return -11'sd1024;
			1:       return 11'sd1023;
			2, 3, 4: return 11'($urandom);
			default: return 11'(int'($urandom_range(16)) - 8);
		endcase
	endfunction

	// Four idle phases. Each phase runs 11 sets of settings with 25 points each.
	// Some sets use a singular basis, and a few use out-of-range frac_bits.
	task automatic test_random_sets();
		int                        idle_plan [4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{38, 38}};
		logic signed [BASIS_W-1:0] a, b, c, d;
		logic signed [ORG_W-1:0]   ox, oy;
		logic signed [PT_W-1:0]    x, y;
		logic [FRAC_W-1:0]         fb;
		int                        m;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_plan[ph][0];
			recv_stall_pct = idle_plan[ph][1];
			for (int blk = 0; blk < 11; blk++) begin
				settle();
				b = pick_component();
				d = pick_component();
				if ($urandom_range(9) == 0) begin
					// Make the first vector a multiple of the second, so the
					// determinant is zero.
					m = int'($urandom_range(4)) - 2;
					a = 11'(m * b);
					c = 11'(m * d);
				end else begin
					a = pick_component();
					c = pick_component();
				end
				ox = ($urandom_range(4) == 0) ? 16'sd0 : 16'($urandom);
				oy = ($urandom_range(4) == 0) ? 16'sd0 : 16'($urandom);
				fb = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
				program_lattice(a, b, c, d, ox, oy, fb);
				for (int n = 0; n < 25; n++) begin
					if ($urandom_range(3) != 0) begin
						x = 16'(ox + int'($urandom_range(4000)) - 2000);
						y = 16'(oy + int'($urandom_range(4000)) - 2000);
					end else begin
						x = 16'($urandom);
						y = 16'($urandom);
					end
					send_point(x, y, $urandom_range(7) == 0);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		// Drive every input to a known value before the first edge. Hold reset
		// low, then release it.
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		point_valid <= 1'b0;
		point_x     <= '0;
		point_y     <= '0;
		last_point  <= 1'b0;
		result_ready <= 1'b0;
		lat_a    = 1;
		lat_b    = 0;
		lat_c    = 0;
		lat_d    = 1;
		lat_ox   = 0;
		lat_oy   = 0;
		lat_frac = 5'd8;
		clear_spans();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_extremes();
		test_basis_extremes();
		test_frac_clamp();
		test_singular_and_spare();
		test_random_sets();

		// Wait for all results to drain, then for one more point time. Any
		// extra result that comes in this window is flagged by the sink.
		settle();
		repeat (SEQ_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("lattice_point_projection_top_test: PASS");
		else
			$display("lattice_point_projection_top_test: FAIL");
		$finish;
	end

endmodule
